// ----- rtl/usi_pkg.sv -----
// Package: shared types, action codes and defaults for the set intersection block.
`timescale 1ns / 1ps

package usi_pkg;

	localparam int SET_DEPTH_DEF = 256;
	localparam int ID_BITS_DEF   = 16;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_PROBE  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] member_id;
		logic        last;
	} req_t;

	typedef struct packed {
		logic [15:0] matched_id;
		logic        hit;
		logic        pass_end;
		logic [15:0] match_count;
		logic        nonempty;
		logic        store_overflow;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic take;
		logic issue;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_probe;
		logic empty;
		logic last_issue;
		logic slot_free;
	} status_t;

endpackage

// ----- rtl/unsorted_set_intersection_top.sv -----
// Flow: clear and append are taken in ST_IDLE; a probe with n stored ids (n <= SET_DEPTH) goes
// through ST_SCAN, ST_DRAIN and ST_RESULT (straight to ST_RESULT on an empty store).
// A new request is taken only back in ST_IDLE, so probes do not overlap. The scan reads through
// the single memory read port, one stored id per cycle. Results wait in an output register.
// Reset: arst_n clears control, counts and flags; the id store is not cleared.
`timescale 1ns / 1ps

module unsorted_set_intersection_top #(
	parameter int SET_DEPTH = usi_pkg::SET_DEPTH_DEF,
	parameter int ID_BITS   = usi_pkg::ID_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  usi_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output usi_pkg::rsp_t rsp
);

	usi_pkg::cmd_t    cmd;
	usi_pkg::status_t status;

	usi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	usi_dp #(
		.SET_DEPTH (SET_DEPTH),
		.ID_BITS   (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/usi_ctrl.sv -----
// Controller: sequences accept, memory scan and result write-back.
`timescale 1ns / 1ps

module usi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  usi_pkg::status_t status,
	output usi_pkg::cmd_t    cmd
);

	usi_pkg::state_t state_q;
	usi_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			usi_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					if (status.is_probe) begin
						state_d = status.empty ? usi_pkg::ST_RESULT : usi_pkg::ST_SCAN;
					end
				end
			end
			usi_pkg::ST_SCAN: begin
				cmd.issue = 1'b1;
				if (status.last_issue) begin
					state_d = usi_pkg::ST_DRAIN;
				end
			end
			usi_pkg::ST_DRAIN: begin
				state_d = usi_pkg::ST_RESULT;
			end
			usi_pkg::ST_RESULT: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = usi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = usi_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/usi_dp.sv -----
// Datapath: id store memory, scan compare, pass counters and result register.
`timescale 1ns / 1ps

module usi_dp #(
	parameter int SET_DEPTH = usi_pkg::SET_DEPTH_DEF,
	parameter int ID_BITS   = usi_pkg::ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  usi_pkg::req_t     req,
	input  usi_pkg::cmd_t     cmd,
	output usi_pkg::status_t  status,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output usi_pkg::rsp_t     rsp
);

	localparam int KEY_BITS = (ID_BITS < 16) ? ID_BITS : 16;
	localparam int IDX_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CNT_W    = $clog2(SET_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(SET_DEPTH);

	logic [KEY_BITS-1:0] mem [SET_DEPTH];

	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic [15:0]         pass_q;
	logic [KEY_BITS-1:0] probe_id_q;
	logic                probe_last_q;
	logic [IDX_W-1:0]    idx_q;
	logic [KEY_BITS-1:0] rd_s1;
	logic                rd_vld_s1;
	logic                hit_q;
	logic                rsp_valid_q;
	usi_pkg::rsp_t       rsp_q;

	logic [KEY_BITS-1:0] key;
	logic                do_append;
	logic                do_clear;
	logic [15:0]         pass_next;

	assign key       = req.member_id[KEY_BITS-1:0];
	assign do_clear  = cmd.take && (req.action == usi_pkg::ACT_CLEAR);
	assign do_append = cmd.take && (req.action == usi_pkg::ACT_APPEND);

	assign status.is_probe   = (req.action == usi_pkg::ACT_PROBE);
	assign status.empty      = (count_q == '0);
	assign status.last_issue = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));
	assign status.slot_free  = !rsp_valid_q || rsp_ready;

	assign pass_next = (hit_q && (pass_q != usi_pkg::COUNT_MAX)) ? pass_q + 16'd1 : pass_q;

	// store memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_append && (count_q < FULL)) begin
			mem[count_q[IDX_W-1:0]] <= key;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			probe_id_q   <= key;
			probe_last_q <= req.last;
		end
		if (cmd.emit) begin
			rsp_q.matched_id     <= 16'(probe_id_q);
			rsp_q.hit            <= hit_q;
			rsp_q.pass_end       <= probe_last_q;
			rsp_q.match_count    <= pass_next;
			rsp_q.nonempty       <= (pass_next != 16'd0);
			rsp_q.store_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			pass_q      <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (do_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (do_append) begin
				if (count_q < FULL) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.take) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (rd_vld_s1 && (rd_s1 == probe_id_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				pass_q      <= probe_last_q ? 16'd0 : pass_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- tb/unsorted_set_intersection_top_tb.sv -----
// Testbench: self-checking random and directed test of the set intersection block.
`timescale 1ns / 1ps

module unsorted_set_intersection_top_tb;

	localparam int          SET_DEPTH    = usi_pkg::SET_DEPTH_DEF;
	localparam int          ITEM_TARGET  = 1200;
	localparam int          BURST_PROBES = 40;
	localparam int          STALL_AT     = 150;
	localparam int          STALL_CYCLES = 600;
	localparam int          DRAIN_CYCLES = 300;
	localparam int          REPORT_MAX   = 10;
	localparam longint      CYCLE_LIMIT  = 3000000;
	localparam logic [1:0]  ACT_NONE     = 2'd3;

	typedef struct {
		usi_pkg::req_t pkt;
		bit            hold;
		bit            fast;
	} pending_cmd_t;

	typedef struct {
		usi_pkg::rsp_t rsp;
		bit            fast;
	} probe_answer_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	usi_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	usi_pkg::rsp_t rsp;

	pending_cmd_t  cmd_q[$];
	probe_answer_t answer_q[$];

	logic [15:0] held_ids[SET_DEPTH];
	int unsigned held_len      = 0;
	logic        held_overflow = 1'b0;
	logic [15:0] pass_hits     = '0;

	bit          req_taken  = 1'b0;
	bit          rsp_taken  = 1'b0;
	bit          req_fast   = 1'b0;
	bit          rsp_fast   = 1'b0;
	int unsigned send_gap   = 0;
	int unsigned take_gap   = 0;
	int unsigned rsp_total  = 0;
	int unsigned err_count  = 0;
	int unsigned item_total = 0;
	longint      cycle_cnt  = 0;

	unsorted_set_intersection_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	function automatic bit lookup_answer(input usi_pkg::req_t r, output usi_pkg::rsp_t a);
		bit found;
		a = '0;
		found = 1'b0;
		case (r.action)
			usi_pkg::ACT_CLEAR: begin
				held_len = 0;
				held_overflow = 1'b0;
				return 1'b0;
			end
			usi_pkg::ACT_APPEND: begin
				if (held_len < SET_DEPTH) begin
					held_ids[held_len] = r.member_id;
					held_len++;
				end else begin
					held_overflow = 1'b1;
				end
				return 1'b0;
			end
			usi_pkg::ACT_PROBE: begin
				for (int i = 0; i < held_len; i++)
					if (held_ids[i] == r.member_id)
						found = 1'b1;
				if (found && pass_hits != usi_pkg::COUNT_MAX)
					pass_hits++;
				a.matched_id     = r.member_id;
				a.hit            = found;
				a.pass_end       = r.last;
				a.match_count    = pass_hits;
				a.nonempty       = (pass_hits != '0);
				a.store_overflow = held_overflow;
				if (r.last)
					pass_hits = '0;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic logic [15:0] rand_id();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return 16'($urandom_range(0, 7));
		else if (sel == 4)
			return 16'($urandom_range(16'hFFF8, 16'hFFFF));
		else
			return 16'($urandom());
	endfunction

	task automatic queue_item(input logic [1:0] action, input logic [15:0] id, input logic last,
			input bit hold, input bit fast);
		pending_cmd_t c;
		c.pkt.action    = action;
		c.pkt.member_id = id;
		c.pkt.last      = last;
		c.hold          = hold;
		c.fast          = fast;
		cmd_q.push_back(c);
		if (action != ACT_NONE)
			item_total++;
	endtask

	// driver: one transaction at a time, random gap before each unless it is marked fast
	always @(negedge clk) begin : drive
		int unsigned gap;
		logic        offer;
		if (arst_n) begin
			gap = send_gap;
			offer = req_valid;
			if (req_valid && req_taken) begin
				offer = 1'b0;
				gap = (cmd_q.size() != 0 && cmd_q[0].fast) ? 0 : $urandom_range(0, 5);
			end
			if (!offer) begin
				if (gap != 0) begin
					gap--;
				end else if (cmd_q.size() != 0 && (!cmd_q[0].hold || answer_q.size() == 0)) begin
					req <= cmd_q[0].pkt;
					req_fast <= cmd_q[0].fast;
					cmd_q.pop_front();
					offer = 1'b1;
				end
			end
			req_valid <= offer;
			send_gap <= gap;
		end
	end

	// receiver: random back-pressure, one long hold-off
	always @(negedge clk) begin : receive
		int unsigned gap;
		if (arst_n) begin
			gap = take_gap;
			if (rsp_taken) begin
				if (rsp_total == STALL_AT)
					gap = STALL_CYCLES;
				else if (rsp_fast)
					gap = 0;
				else
					gap = $urandom_range(0, 5);
			end
			if (gap != 0) begin
				rsp_ready <= 1'b0;
				take_gap <= gap - 1;
			end else begin
				rsp_ready <= 1'b1;
				take_gap <= 0;
			end
		end
	end

	// monitor: predict on request transaction, check on response transaction
	always @(posedge clk) begin : monitor
		usi_pkg::rsp_t want;
		probe_answer_t ans;
		req_taken <= req_valid && req_ready;
		rsp_taken <= rsp_valid && rsp_ready;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_total <= rsp_total + 1;
				if (answer_q.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display("unexpected response: id=%h hit=%b end=%b cnt=%h ne=%b ovf=%b",
							rsp.matched_id, rsp.hit, rsp.pass_end, rsp.match_count,
							rsp.nonempty, rsp.store_overflow);
				end else begin
					ans = answer_q.pop_front();
					rsp_fast <= ans.fast;
					if (rsp.matched_id !== ans.rsp.matched_id || rsp.hit !== ans.rsp.hit ||
							rsp.pass_end !== ans.rsp.pass_end ||
							rsp.match_count !== ans.rsp.match_count ||
							rsp.nonempty !== ans.rsp.nonempty ||
							rsp.store_overflow !== ans.rsp.store_overflow) begin
						err_count++;
						if (err_count <= REPORT_MAX) begin
							$write("mismatch: expected id=%h hit=%b end=%b cnt=%h ne=%b ovf=%b",
								ans.rsp.matched_id, ans.rsp.hit, ans.rsp.pass_end,
								ans.rsp.match_count, ans.rsp.nonempty, ans.rsp.store_overflow);
							$display(" got id=%h hit=%b end=%b cnt=%h ne=%b ovf=%b",
								rsp.matched_id, rsp.hit, rsp.pass_end, rsp.match_count,
								rsp.nonempty, rsp.store_overflow);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				if (lookup_answer(req, want)) begin
					ans.rsp = want;
					ans.fast = req_fast;
					answer_q.push_back(ans);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("unsorted_set_intersection_top_tb failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned   k;
		int unsigned   n;
		int unsigned   pick;
		logic [15:0]   id;
		logic [15:0]   loaded[$];

		// probe before any clear, unused action
		queue_item(usi_pkg::ACT_PROBE, 16'h0000, 1'b0, 1'b0, 1'b0);
		queue_item(ACT_NONE, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_CLEAR, 16'h0000, 1'b0, 1'b0, 1'b0);
		// duplicates in store, extreme ids
		queue_item(usi_pkg::ACT_APPEND, 16'h0000, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_APPEND, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_APPEND, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_APPEND, 16'h1234, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'h0000, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'h5555, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_APPEND, 16'h0003, 1'b1, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'h0003, 1'b1, 1'b0, 1'b0);
		// clear keeps the running count
		queue_item(usi_pkg::ACT_PROBE, 16'h0000, 1'b0, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_CLEAR, 16'hFFFF, 1'b1, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'h0000, 1'b1, 1'b0, 1'b0);
		queue_item(usi_pkg::ACT_PROBE, 16'hAAAA, 1'b1, 1'b0, 1'b0);

		while (item_total < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				queue_item(usi_pkg::ACT_CLEAR, rand_id(), 1'($urandom_range(0, 1)),
					(item_total < 40) || ($urandom_range(0, 19) == 0), 1'b0);
				if ($urandom_range(0, 24) == 0)
					n = $urandom_range(SET_DEPTH - 6, SET_DEPTH + 6);
				else
					n = $urandom_range(0, 12);
				loaded.delete();
				repeat (n) begin
					id = rand_id();
					loaded.push_back(id);
					queue_item(usi_pkg::ACT_APPEND, id, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
				end
				n = $urandom_range(1, 10);
				for (k = 0; k < n; k++) begin
					if (loaded.size() != 0 && $urandom_range(0, 9) < 6)
						id = loaded[$urandom_range(0, loaded.size() - 1)];
					else
						id = rand_id();
					queue_item(usi_pkg::ACT_PROBE, id, k == n - 1, 1'b0, 1'b0);
				end
			end else begin
				repeat ($urandom_range(1, 4))
					queue_item(2'($urandom_range(0, 3)), rand_id(), 1'($urandom_range(0, 1)),
						1'b0, 1'b0);
			end
		end

		// back-to-back probes in one pass and a one-probe pass after it, no idling
		queue_item(usi_pkg::ACT_CLEAR, 16'h0000, 1'b0, 1'b1, 1'b1);
		queue_item(usi_pkg::ACT_APPEND, 16'h5A5A, 1'b0, 1'b0, 1'b1);
		for (k = 0; k < BURST_PROBES; k++)
			queue_item(usi_pkg::ACT_PROBE, 16'h5A5A, 1'b0, 1'b0, 1'b1);
		queue_item(usi_pkg::ACT_PROBE, 16'h5A5A, 1'b1, 1'b0, 1'b1);
		queue_item(usi_pkg::ACT_PROBE, 16'h5A5A, 1'b1, 1'b0, 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || req_valid)
			@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0 && answer_q.size() == 0) begin
			$display("unsorted_set_intersection_top_tb passed");
		end else begin
			$display("unsorted_set_intersection_top_tb failed");
		end
		$finish;
	end

endmodule
